[rtl/core/kwsm_pkg.sv]
// Package for the k-way sorted merge core.
// Holds the transaction payload types and operation codes shared by the RTL.
// No dependencies.
`default_nettype none

package kwsm_pkg;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam int LIST_INDEX_W = 2;
    localparam int VALUE_W      = 32;
    localparam int LISTS        = 4;

    typedef struct packed {
        logic                     op;
        logic [LIST_INDEX_W-1:0]  list_index;
        logic signed [VALUE_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] merged_value;
        logic [LIST_INDEX_W-1:0]   source_list;
        logic                      last_result;
        logic                      empty_res;
        logic                      overflow;
    } out_t;

endpackage

`default_nettype wire

[rtl/core/k_way_sorted_merge_core.sv]
// Top level of the k-way sorted merge core.
// Depends on kwsm_pkg for the payload types and operation codes.
`default_nettype none

// An append transaction writes its value to the element memory of its list,
// or sets the overflow flag if that list is full. A finish transaction starts
// the merge: for each result a small sequencer walks the LISTS heads through
// the single read port of the element memory and one shared signed
// comparator, and each result may wait on m_ready for the output register. A
// finish with nothing loaded goes straight to the output state and gives its
// single empty result. The input side is not ready while a merge runs, and it
// takes new transactions as soon as the last result is in the output register.
module k_way_sorted_merge_core
    import kwsm_pkg::*;
#(
    parameter int PER_LIST_DEPTH = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    localparam int LW    = $clog2(LISTS);
    localparam int SW    = $clog2(LISTS + 1);
    localparam int CW    = $clog2(PER_LIST_DEPTH + 1);
    localparam int DEPTH = LISTS * PER_LIST_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PUT
    } state_t;

    state_t state_reg;

    logic [CW-1:0] fill_reg [LISTS];
    logic [CW-1:0] pos_reg [LISTS];
    logic [TW-1:0] total_reg;
    logic [TW-1:0] remaining_reg;
    logic          overflow_reg;

    logic [SW-1:0] scan_reg;
    logic          pend_valid_reg;
    logic          pend_ok_reg;
    logic [LW-1:0] pend_list_reg;
    logic          found_reg;
    logic          empty_reg;
    logic signed [VALUE_W-1:0] best_val_reg;
    logic [LW-1:0] best_list_reg;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] mem_q_reg;

    logic          m_valid_reg;
    out_t          m_data_reg;

    logic          s_fire;
    logic          out_free;
    logic          list_ok;
    logic [LW-1:0] idx;
    logic [CW-1:0] idx_fill;
    logic [CW-1:0] idx_pos;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic          take_better;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign list_ok  = (32'(s_data.list_index) < LISTS);
    assign idx      = (state_reg == ST_IDLE) ? LW'(s_data.list_index) : scan_reg[LW-1:0];
    assign idx_fill = fill_reg[idx];
    assign idx_pos  = pos_reg[idx];

    assign wr_en   = s_fire && (s_data.op == OP_APPEND) && list_ok
                     && (32'(idx_fill) < PER_LIST_DEPTH);
    assign wr_addr = AW'(32'(idx) * PER_LIST_DEPTH + 32'(idx_fill));
    assign rd_addr = AW'(32'(idx) * PER_LIST_DEPTH + 32'(idx_pos));

    assign take_better = pend_valid_reg && pend_ok_reg
                         && (!found_reg || ($signed(mem_q_reg) < best_val_reg));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= s_data.value;
        end
        mem_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            total_reg      <= '0;
            remaining_reg  <= '0;
            overflow_reg   <= 1'b0;
            scan_reg       <= '0;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            empty_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < LISTS; i++) begin
                fill_reg[i] <= '0;
                pos_reg[i]  <= '0;
            end
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_PUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (s_data.op == OP_APPEND) begin
                            if (list_ok) begin
                                if (32'(idx_fill) < PER_LIST_DEPTH) begin
                                    fill_reg[idx] <= idx_fill + CW'(1);
                                    total_reg     <= total_reg + TW'(1);
                                end else begin
                                    overflow_reg <= 1'b1;
                                end
                            end
                        end else begin
                            for (int i = 0; i < LISTS; i++) begin
                                pos_reg[i] <= '0;
                            end
                            remaining_reg  <= total_reg;
                            scan_reg       <= '0;
                            pend_valid_reg <= 1'b0;
                            found_reg      <= 1'b0;
                            best_val_reg   <= '0;
                            best_list_reg  <= '0;
                            if (total_reg == '0) begin
                                empty_reg <= 1'b1;
                                state_reg <= ST_PUT;
                            end else begin
                                empty_reg <= 1'b0;
                                state_reg <= ST_SCAN;
                            end
                        end
                    end
                end
                ST_SCAN: begin
                    if (take_better) begin
                        found_reg     <= 1'b1;
                        best_val_reg  <= $signed(mem_q_reg);
                        best_list_reg <= pend_list_reg;
                    end
                    if (32'(scan_reg) < LISTS) begin
                        pend_valid_reg <= 1'b1;
                        pend_ok_reg    <= (idx_pos < idx_fill);
                        pend_list_reg  <= idx;
                        scan_reg       <= scan_reg + SW'(1);
                    end else begin
                        pend_valid_reg <= 1'b0;
                        if (!pend_valid_reg) begin
                            state_reg <= ST_PUT;
                        end
                    end
                end
                ST_PUT: begin
                    if (out_free) begin
                        m_valid_reg               <= 1'b1;
                        m_data_reg.merged_value   <= best_val_reg;
                        m_data_reg.source_list    <= LIST_INDEX_W'(best_list_reg);
                        m_data_reg.empty_res      <= empty_reg;
                        m_data_reg.overflow       <= overflow_reg;
                        if (empty_reg || (remaining_reg == TW'(1))) begin
                            m_data_reg.last_result <= 1'b1;
                            for (int i = 0; i < LISTS; i++) begin
                                fill_reg[i] <= '0;
                                pos_reg[i]  <= '0;
                            end
                            total_reg     <= '0;
                            remaining_reg <= '0;
                            empty_reg     <= 1'b0;
                            state_reg     <= ST_IDLE;
                        end else begin
                            m_data_reg.last_result <= 1'b0;
                            pos_reg[best_list_reg] <= pos_reg[best_list_reg] + CW'(1);
                            remaining_reg  <= remaining_reg - TW'(1);
                            scan_reg       <= '0;
                            pend_valid_reg <= 1'b0;
                            found_reg      <= 1'b0;
                            state_reg      <= ST_SCAN;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
